// ===== rtl/text_cursor_glyph_renderer_core_defines.svh =====
// ----------------------------------------------------------------------------
// text cursor glyph renderer assertion macros
// shared assertion forms for the renderer core
// ----------------------------------------------------------------------------
`ifndef TEXT_CURSOR_GLYPH_RENDERER_CORE_DEFINES_SVH
`define TEXT_CURSOR_GLYPH_RENDERER_CORE_DEFINES_SVH

// same-cycle implication
`define TCGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg
// font table, cell geometry and command type of the glyph renderer
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_COLS  = 5;
  localparam int CELL_COLS   = 6;
  localparam int CELL_ROWS   = 7;
  localparam int GLYPH_BITS  = CELL_COLS * CELL_ROWS;
  localparam int QDEPTH      = 2;

  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd126;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;
  localparam logic [7:0] LINE_PITCH    = 8'd8;
  localparam logic [7:0] VERT_BASE     = 8'd219;

  typedef enum logic {
    OP_PRINT      = 1'b0,
    OP_SET_CURSOR = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0]            col;
    logic [7:0]            row;
    logic [GLYPH_BITS-1:0] glyph;
    logic [15:0]           fg;
    logic [15:0]           bg;
  } cmd_t;

  // column 0 in the top byte, bit 0 of a byte is the top row
  localparam logic [39:0] GLYPH_ROM [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
    40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
    40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h007F102844, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h08082A1C08
  };

  // glyph cell bits, column c at [c*7 +: 7], spacing column left clear
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [6:0] sel);
    logic [39:0]           entry;
    logic [GLYPH_BITS-1:0] bits;
    entry = GLYPH_ROM[sel];
    bits  = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      bits[c*CELL_ROWS +: CELL_ROWS] = entry[(GLYPH_COLS-1-c)*8 +: CELL_ROWS];
    end
    return bits;
  endfunction

endpackage

// ===== rtl/tcgr_front.sv =====
// ----------------------------------------------------------------------------
// tcgr_front
// takes items, keeps the text cursor, wraps it and queues print commands
// ----------------------------------------------------------------------------
module tcgr_front #(
  parameter int SCREEN_WIDTH  = 220,
  parameter int SCREEN_HEIGHT = 176
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            op_i,
  input  logic [7:0]      char_code_i,
  input  logic [15:0]     fg_color_i,
  input  logic [15:0]     bg_color_i,
  input  logic [7:0]      new_col_i,
  input  logic [7:0]      new_row_i,
  output logic            cmd_push_o,
  output tcgr_pkg::cmd_t  cmd_o
);

  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic [7:0] code_eff;
  logic [6:0] sel;
  logic       col_wrap;
  logic       row_wrap;
  logic [7:0] col_w;
  logic [7:0] row_c;
  logic [7:0] row_w;
  logic       is_print;

  assign is_print = (tcgr_pkg::op_e'(op_i) == tcgr_pkg::OP_PRINT);

  always_comb begin
    if ((char_code_i < tcgr_pkg::FIRST_CODE) || (char_code_i > tcgr_pkg::LAST_CODE)) begin
      code_eff = tcgr_pkg::FALLBACK_CODE;
    end else begin
      code_eff = char_code_i;
    end
  end

  assign sel = 7'(code_eff - tcgr_pkg::FIRST_CODE);

  assign col_wrap = ({1'b0, col_q} + 9'(tcgr_pkg::CELL_COLS)) > 9'(SCREEN_WIDTH);
  assign col_w    = col_wrap ? 8'd0 : col_q;
  assign row_c    = col_wrap ? (row_q + tcgr_pkg::LINE_PITCH) : row_q;
  assign row_wrap = ({1'b0, row_c} + 9'(tcgr_pkg::CELL_ROWS)) > 9'(SCREEN_HEIGHT);
  assign row_w    = row_wrap ? 8'd0 : row_c;

  always_comb begin
    cmd_o.col   = col_w;
    cmd_o.row   = row_w;
    cmd_o.glyph = tcgr_pkg::glyph_bits(sel);
    cmd_o.fg    = fg_color_i;
    cmd_o.bg    = bg_color_i;
  end

  assign cmd_push_o = accept_i && is_print;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (is_print) begin
        col_d = col_w + 8'(tcgr_pkg::CELL_COLS);
        row_d = row_w;
      end else begin
        col_d = new_col_i;
        row_d = new_row_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 8'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/tcgr_queue.sv =====
// ----------------------------------------------------------------------------
// tcgr_queue
// two-entry command queue between the front and the pixel sequencer
// ----------------------------------------------------------------------------
module tcgr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tcgr_pkg::cmd_t  wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output tcgr_pkg::cmd_t  rdata_o,
  output logic            empty_o
);

  localparam int PW = $clog2(tcgr_pkg::QDEPTH);
  localparam int CW = $clog2(tcgr_pkg::QDEPTH + 1);

  tcgr_pkg::cmd_t mem_q [tcgr_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (count_q == CW'(tcgr_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(tcgr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(tcgr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/tcgr_back.sv =====
// ----------------------------------------------------------------------------
// tcgr_back
// pixel sequencer: walks the 6x7 cell of the queue head into the result register
// ----------------------------------------------------------------------------
module tcgr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcgr_pkg::cmd_t  cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      pixel_col_o,
  output logic [7:0]      pixel_row_o,
  output logic [15:0]     pixel_color_o,
  output logic [7:0]      gram_horiz_o,
  output logic [7:0]      gram_vert_o,
  output logic            last_pixel_o
);

  logic [2:0]  r_q, r_d;
  logic [2:0]  c_q, c_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  col_q, row_q, vert_q;
  logic [15:0] color_q;
  logic        last_q;
  logic        advance;
  logic        cell_end;
  logic        row_end;
  logic [5:0]  bit_idx;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [15:0] color;

  assign advance  = !cmd_empty_i && (!out_valid_q || pop_i);
  assign row_end  = (c_q == 3'(tcgr_pkg::CELL_COLS - 1));
  assign cell_end = row_end && (r_q == 3'(tcgr_pkg::CELL_ROWS - 1));
  assign bit_idx  = 6'(c_q) * 6'(tcgr_pkg::CELL_ROWS) + 6'(r_q);
  assign x        = cmd_i.col + 8'(c_q);
  assign y        = cmd_i.row + 8'(r_q);
  assign color    = cmd_i.glyph[bit_idx] ? cmd_i.fg : cmd_i.bg;
  assign cmd_pop_o = advance && cell_end;

  always_comb begin
    r_d = r_q;
    c_d = c_q;
    if (advance) begin
      if (row_end) begin
        c_d = '0;
        r_d = cell_end ? 3'd0 : r_q + 1'b1;
      end else begin
        c_d = c_q + 1'b1;
      end
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      r_q         <= r_d;
      c_q         <= c_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      col_q   <= x;
      row_q   <= y;
      vert_q  <= tcgr_pkg::VERT_BASE - x;
      color_q <= color;
      last_q  <= cell_end;
    end
  end

  assign empty_o       = !out_valid_q;
  assign pixel_col_o   = col_q;
  assign pixel_row_o   = row_q;
  assign pixel_color_o = color_q;
  assign gram_horiz_o  = row_q;
  assign gram_vert_o   = vert_q;
  assign last_pixel_o  = last_q;

endmodule

// ===== rtl/text_cursor_glyph_renderer_core.sv =====
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer_core
// 5x7 font character generator with a wrapping text cursor
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------------
//   items     push / full          op, char_code, fg_color, bg_color, new_col/row
//   pixels    pop / empty          pixel_col/row/color, gram_horiz/vert, last_pixel
//
// a print gives 42 pixel transfers, one per cycle while pop keeps the result register drained
// a set-cursor item only moves the cursor and gives no transfer
// the two-entry command queue lets items arrive while a cell is still drawn
// first pixel passes through the command queue, then the result register, to the result ports
// reset puts the cursor at 0,0 and empties the queue and result register
// full stays high while the queue holds two prints, the one being drawn included
// ----------------------------------------------------------------------------
`include "text_cursor_glyph_renderer_core_defines.svh"

module text_cursor_glyph_renderer_core #(
  parameter int SCREEN_WIDTH  = 220,
  parameter int SCREEN_HEIGHT = 176
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  char_code_i,
  input  logic [15:0] fg_color_i,
  input  logic [15:0] bg_color_i,
  input  logic [7:0]  new_col_i,
  input  logic [7:0]  new_row_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_col_o,
  output logic [7:0]  pixel_row_o,
  output logic [15:0] pixel_color_o,
  output logic [7:0]  gram_horiz_o,
  output logic [7:0]  gram_vert_o,
  output logic        last_pixel_o
);

  tcgr_pkg::cmd_t q_wdata;
  tcgr_pkg::cmd_t q_rdata;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  logic           in_accept;

  assign full      = q_full;
  assign in_accept = push && !q_full;

  tcgr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .fg_color_i  (fg_color_i),
    .bg_color_i  (bg_color_i),
    .new_col_i   (new_col_i),
    .new_row_i   (new_row_i),
    .cmd_push_o  (q_push),
    .cmd_o       (q_wdata)
  );

  tcgr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  tcgr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (q_rdata),
    .cmd_empty_i   (q_empty),
    .cmd_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .pixel_col_o   (pixel_col_o),
    .pixel_row_o   (pixel_row_o),
    .pixel_color_o (pixel_color_o),
    .gram_horiz_o  (gram_horiz_o),
    .gram_vert_o   (gram_vert_o),
    .last_pixel_o  (last_pixel_o)
  );

  `TCGR_ASSERT_NOW(a_push_not_full, q_push, !q_full, "print queued while queue full")
  `TCGR_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "command retired from empty queue")
  `TCGR_ASSERT_NEXT(a_retire_last, q_pop, !empty && last_pixel_o, "retire missed last pixel")

endmodule
